@@ rtl/core/metb_pkg.sv @@
// ----------------------------------------------------------------------------
// metb_pkg
// shared constants and types for the mesh edge table builder
// ----------------------------------------------------------------------------
`default_nettype none
package metb_pkg;
  localparam int unsigned MAX_EDGES_DEF   = 1024;
  localparam int unsigned COUNT_WIDTH_DEF = 8;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned TOTAL_W  = 11;

  // result of one edge lookup, passed from the lane merge to the control
  typedef struct packed {
    logic        hit;
    logic        rev;
    logic [15:0] pos;
  } metb_hit_t;
endpackage
`default_nettype wire

@@ rtl/core/metb_lane.sv @@
// ----------------------------------------------------------------------------
// metb_lane
// one lane: compares a stored edge against the edge under search
// ----------------------------------------------------------------------------
`default_nettype none
module metb_lane (
  input  wire logic [metb_pkg::IDX_W-1:0] ent_s,
  input  wire logic [metb_pkg::IDX_W-1:0] ent_f,
  input  wire logic                       ent_valid,
  input  wire logic [metb_pkg::IDX_W-1:0] key_1,
  input  wire logic [metb_pkg::IDX_W-1:0] key_2,
  output logic                            fwd,
  output logic                            bwd
);
  import metb_pkg::*;
  assign fwd = ent_valid && (ent_s == key_1) && (ent_f == key_2);
  assign bwd = ent_valid && (ent_s == key_2) && (ent_f == key_1);
endmodule
`default_nettype wire

@@ rtl/core/metb_merge.sv @@
// ----------------------------------------------------------------------------
// metb_merge
// registered priority merge of the lane results: lowest matching entry wins
// ----------------------------------------------------------------------------
`default_nettype none
module metb_merge #(
  parameter int unsigned LANES = 4,
  parameter int unsigned POS_W = 2
) (
  input  wire logic                     clk,
  input  wire logic [LANES-1:0]         fwd,
  input  wire logic [LANES-1:0]         bwd,
  input  wire logic [POS_W-1:0]         base,
  output metb_pkg::metb_hit_t           hit_r
);
  import metb_pkg::*;
  metb_hit_t hit_nxt;
  always_comb begin
    hit_nxt = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (fwd[i] || bwd[i]) begin
        hit_nxt.hit = 1'b1;
        hit_nxt.rev = !fwd[i];
        hit_nxt.pos = 16'(base) + 16'(i);
      end
    end
  end
  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/core/mesh_edge_table_builder_core.sv @@
// per triangle: each edge scans R = ceil(stored edges / LANES) rows, LANES entries per cycle;
//   then the use counts are read and written and the result is registered for out_valid
// rejected triangles skip the count update; with an empty table no rows are scanned;
//   degenerate triangles skip both the scan and the count update
// throughput: one triangle at a time; next input transfer in the cycle after the result one
// reset: edge count and unbalanced count clear; neither store is cleared, only entries below
// ----------------------------------------------------------------------------
// mesh_edge_table_builder_core
// edge deduplication for a triangle stream with signed saturating use counts
// ----------------------------------------------------------------------------
`default_nettype none
module mesh_edge_table_builder_core #(
  parameter int unsigned MAX_EDGES   = metb_pkg::MAX_EDGES_DEF,
  parameter int unsigned COUNT_WIDTH = metb_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_vertex_a_index,
  input  wire logic [15:0] in_vertex_b_index,
  input  wire logic [15:0] in_vertex_c_index,
  input  wire logic signed [31:0] in_vertex_a_x,
  input  wire logic signed [31:0] in_vertex_a_y,
  input  wire logic signed [31:0] in_vertex_a_z,
  input  wire logic signed [31:0] in_vertex_b_x,
  input  wire logic signed [31:0] in_vertex_b_y,
  input  wire logic signed [31:0] in_vertex_b_z,
  input  wire logic signed [31:0] in_vertex_c_x,
  input  wire logic signed [31:0] in_vertex_c_y,
  input  wire logic signed [31:0] in_vertex_c_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       out_edge_ab_index,
  output logic             out_edge_ab_reversed,
  output logic [9:0]       out_edge_bc_index,
  output logic             out_edge_bc_reversed,
  output logic [9:0]       out_edge_ca_index,
  output logic             out_edge_ca_reversed,
  output logic             out_degenerate,
  output logic             out_table_full,
  output logic             out_mesh_closed,
  output logic [10:0]      out_edges_stored
);
  import metb_pkg::*;

  // the edge count is read, a new edge's use count starts from zero

  localparam int unsigned LANES  = 4;
  localparam int unsigned AW     = $clog2(MAX_EDGES);
  localparam int unsigned TW     = $clog2(MAX_EDGES + 1);
  localparam int unsigned ROWS   = (MAX_EDGES + LANES - 1) / LANES;
  localparam int unsigned RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned LW     = $clog2(LANES);
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_DRAIN = 9'b000000100,
    S_NEXT  = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_CRD   = 9'b000100000,
    S_CWR   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // captured triangle
  logic [15:0] v_r [3];
  logic [2:0]  ptgt_r;              // point of edge i greater than its next point
  logic [1:0]  e_r;                 // edge under search or under update
  logic [RW-1:0] row_r;
  logic        drain_r;             // merge stage result is due this cycle

  // per edge results
  logic [2:0]  hit_r, rev_r;
  logic [AW-1:0] idx_r [3];
  logic [TW-1:0] total_r;
  logic [TW-1:0] unbal_r;
  logic        degen_r, full_r;

  // edge store: LANES banks, one row read per cycle
  logic [31:0] bank [LANES][ROWS];
  logic [31:0] rd_r [LANES];
  logic        rdv_r [LANES];
  logic [RW-1:0] rd_row_r;

  // use counts; not cleared at reset, a new edge's count is taken as zero instead of read here
  logic signed [COUNT_WIDTH-1:0] cnt_mem [MAX_EDGES];
  logic signed [COUNT_WIDTH-1:0] cnt_rd_r;

  logic [15:0] key1, key2;
  logic [LANES-1:0] fwd, bwd;
  metb_hit_t mrg;

  assign key1 = v_r[e_r];
  assign key2 = v_r[(e_r == 2'd2) ? 2'd0 : e_r + 2'd1];

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      rd_r[l]  <= bank[l][row_r];
      rdv_r[l] <= ((TW+1)'(row_r) * (TW+1)'(LANES) + (TW+1)'(l)) < (TW+1)'(total_r);
    end
    rd_row_r <= row_r;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    metb_lane u_lane (
      .ent_s(rd_r[l][15:0]), .ent_f(rd_r[l][31:16]), .ent_valid(rdv_r[l]),
      .key_1(key1), .key_2(key2), .fwd(fwd[l]), .bwd(bwd[l])
    );
  end

  metb_merge #(.LANES(LANES), .POS_W(RW + LW)) u_merge (
    .clk(clk), .fwd(fwd), .bwd(bwd),
    .base((RW + LW)'({rd_row_r, {LW{1'b0}}})),
    .hit_r(mrg)
  );

  // lexicographic compare of point i against its next point
  function automatic logic pgt(input logic signed [31:0] px, py, pz, qx, qy, qz);
    if (px != qx) return px > qx;
    if (py != qy) return py > qy;
    return pz > qz;
  endfunction

  logic [1:0] fresh_n;
  logic [TW:0] need;
  logic [1:0] e_nx;
  logic [TW-1:0] new_pos;
  logic        edge_fresh;
  logic        edge_rev;
  logic [AW-1:0] edge_idx;
  logic signed [COUNT_WIDTH-1:0] cold, cnew;

  always_comb begin
    fresh_n = 2'(!hit_r[0]) + 2'(!hit_r[1]) + 2'(!hit_r[2]);
    need = (TW+1)'(total_r) + (TW+1)'(fresh_n);
    e_nx = (e_r == 2'd2) ? 2'd0 : e_r + 2'd1;
    edge_fresh = !hit_r[e_r];
    edge_rev = rev_r[e_r];
    edge_idx = edge_fresh ? AW'(total_r) : idx_r[e_r];
    new_pos = total_r;
    cold = cnt_rd_r;
    cnew = cold;
    if (edge_rev) begin
      if (cold != CNT_MIN) cnew = cold - 1'b1;
    end else begin
      if (cold != CNT_MAX) cnew = cold + 1'b1;
    end
  end

  // scan ends when all rows holding edges are issued
  logic last_row;
  assign last_row = ((TW+1)'(row_r) + 1'b1) * (TW+1)'(LANES) >= (TW+1)'(total_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_DEC;
      S_DEC:   state_nxt = degen_r ? S_OUT : (total_r == '0 ? S_NEXT : S_SCAN);
      S_SCAN:  if (last_row) state_nxt = S_DRAIN;
      S_DRAIN: if (drain_r) state_nxt = S_NEXT;
      S_NEXT: begin
        if (e_r != 2'd2) state_nxt = (total_r == '0) ? S_NEXT : S_SCAN;
        else if (need > (TW+1)'(MAX_EDGES)) state_nxt = S_OUT;
        else state_nxt = S_CRD;
      end
      S_CRD:   state_nxt = S_CWR;
      S_CWR:   state_nxt = (e_r == 2'd2) ? S_OUT : S_CRD;
      S_OUT:   state_nxt = S_FIN;
      S_FIN:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      unbal_r   <= '0;
      e_r       <= '0;
      row_r     <= '0;
      drain_r   <= 1'b0;
      hit_r     <= '0;
      rev_r     <= '0;
      degen_r   <= 1'b0;
      full_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          v_r[0] <= in_vertex_a_index;
          v_r[1] <= in_vertex_b_index;
          v_r[2] <= in_vertex_c_index;
          ptgt_r[0] <= pgt(in_vertex_a_x, in_vertex_a_y, in_vertex_a_z,
                           in_vertex_b_x, in_vertex_b_y, in_vertex_b_z);
          ptgt_r[1] <= pgt(in_vertex_b_x, in_vertex_b_y, in_vertex_b_z,
                           in_vertex_c_x, in_vertex_c_y, in_vertex_c_z);
          ptgt_r[2] <= pgt(in_vertex_c_x, in_vertex_c_y, in_vertex_c_z,
                           in_vertex_a_x, in_vertex_a_y, in_vertex_a_z);
          degen_r <= (in_vertex_a_index == in_vertex_b_index) ||
                     (in_vertex_a_index == in_vertex_c_index) ||
                     (in_vertex_b_index == in_vertex_c_index);
          full_r <= 1'b0;
          hit_r  <= '0;
          e_r    <= '0;
          row_r  <= '0;
        end
        S_DEC: begin
          row_r <= '0;
          // default for a miss: orientation from the point order
          rev_r[0] <= ptgt_r[0];
        end
        S_SCAN: begin
          if (last_row) drain_r <= 1'b0;
          else row_r <= row_r + 1'b1;
          // the result of a row passes the read register and the merge register
          if (mrg.hit && !hit_r[e_r] && row_r != '0) begin
            hit_r[e_r] <= 1'b1;
            rev_r[e_r] <= mrg.rev;
            idx_r[e_r] <= AW'(mrg.pos);
          end
        end
        S_DRAIN: begin
          drain_r <= 1'b1;
          if (mrg.hit && !hit_r[e_r]) begin
            hit_r[e_r] <= 1'b1;
            rev_r[e_r] <= mrg.rev;
            idx_r[e_r] <= AW'(mrg.pos);
          end
        end
        S_NEXT: begin
          drain_r <= 1'b0;
          row_r   <= '0;
          if (e_r != 2'd2) begin
            e_r <= e_r + 2'd1;
            rev_r[e_r + 2'd1] <= ptgt_r[e_r + 2'd1];
          end else if (need > (TW+1)'(MAX_EDGES)) begin
            full_r <= 1'b1;
          end else begin
            e_r <= 2'd0;
          end
        end
        S_CRD: begin
          cnt_rd_r <= edge_fresh ? '0 : cnt_mem[edge_idx];
        end
        S_CWR: begin
          if (edge_fresh) begin
            for (int l = 0; l < LANES; l++)
              if (LW'(new_pos) == LW'(l))
                bank[l][RW'(new_pos >> LW)] <= edge_rev ? {key1, key2} : {key2, key1};
            total_r <= total_r + 1'b1;
            hit_r[e_r] <= 1'b1;
            idx_r[e_r] <= AW'(total_r);
          end
          cnt_mem[edge_idx] <= cnew;
          if (cold == '0 && cnew != '0) unbal_r <= unbal_r + 1'b1;
          if (cold != '0 && cnew == '0 && unbal_r != '0) unbal_r <= unbal_r - 1'b1;
          e_r <= e_nx;
        end
        S_OUT, S_FIN: ;
        default: ;
      endcase
    end
  end

  // output register
  logic ok;
  assign ok = !degen_r && !full_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_edge_ab_index    <= ok ? 10'(idx_r[0]) : '0;
      out_edge_bc_index    <= ok ? 10'(idx_r[1]) : '0;
      out_edge_ca_index    <= ok ? 10'(idx_r[2]) : '0;
      out_edge_ab_reversed <= ok && rev_r[0];
      out_edge_bc_reversed <= ok && rev_r[1];
      out_edge_ca_reversed <= ok && rev_r[2];
      out_degenerate       <= degen_r;
      out_table_full       <= full_r;
      out_mesh_closed      <= unbal_r == '0;
      out_edges_stored     <= 11'(total_r);
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = state_r == S_FIN;

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (TW+1)'(total_r) <= (TW+1)'(MAX_EDGES)) else $error("edge count overflow");
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_skip_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CWR) |-> !degen_r) else $error("degenerate triangle updated");
  a_total_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> $stable(total_r)) else $error("edge count moved at output");
`endif
endmodule
`default_nettype wire

@@ sim/mesh_edge_table_builder_core_tb.sv @@
// ----------------------------------------------------------------------------
// mesh_edge_table_builder_core_tb
// self-checking bench: triangles go in through a valid/ready channel, a
// scoreboard keeps its own copy of the edge table and use counts, works out
// each answer when a triangle transfer is taken, and checks every result
// transfer against the oldest answer still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module mesh_edge_table_builder_core_tb;
  import metb_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int CNT_HI      = 127;
  localparam int CNT_LO      = -128;

  // one triangle as it crosses the input channel
  typedef struct {
    logic [15:0]        vid [3];
    logic signed [31:0] pos [3][3];
  } triangle_t;

  // one result, edges in the order ab, bc, ca
  typedef struct packed {
    logic [2:0][OUT_IDX_W-1:0] idx;
    logic [2:0]                rev;
    logic                      degenerate;
    logic                      table_full;
    logic                      mesh_closed;
    logic [TOTAL_W-1:0]        edges_stored;
  } edge_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the edge table, answers per triangle
  // --------------------------------------------------------------------------
  class edge_table_scoreboard;
    logic [15:0]  edge_from [TABLE_DEPTH];
    logic [15:0]  edge_to   [TABLE_DEPTH];
    int           use_cnt   [TABLE_DEPTH];
    int unsigned  edge_count;
    int unsigned  open_edges;
    edge_result_t answers_q [$];
    int unsigned  mismatches;
    int unsigned  n_checked, n_degen, n_full, n_reused, n_closed;

    function new();
      edge_count = 0;
      open_edges = 0;
      mismatches = 0;
      n_checked = 0; n_degen = 0; n_full = 0; n_reused = 0; n_closed = 0;
      foreach (use_cnt[k]) use_cnt[k] = 0;
    endfunction

    // 1 when vertex i lies lexicographically after vertex j
    function bit lies_after(triangle_t t, int i, int j);
      for (int c = 0; c < 3; c++)
        if (t.pos[i][c] != t.pos[j][c]) return t.pos[i][c] > t.pos[j][c];
      return 1'b0;
    endfunction

    function void bump_count(int k, bit rev);
      int was;
      was = use_cnt[k];
      if (rev) begin
        if (was > CNT_LO) use_cnt[k] = was - 1;
      end else begin
        if (was < CNT_HI) use_cnt[k] = was + 1;
      end
      if (was == 0 && use_cnt[k] != 0) open_edges++;
      if (was != 0 && use_cnt[k] == 0 && open_edges > 0) open_edges--;
    endfunction

    function void note_triangle(triangle_t t);
      edge_result_t r;
      int           slot [3];
      bit           rev  [3];
      bit           fresh [3];
      logic [15:0]  s_from [3];
      logic [15:0]  s_to [3];
      int           n_fresh;
      int           m;
      r = '0;
      n_fresh = 0;
      r.degenerate = (t.vid[0] == t.vid[1]) || (t.vid[0] == t.vid[2]) ||
                     (t.vid[1] == t.vid[2]);
      if (!r.degenerate) begin
        // look up every edge of the triangle before anything is appended
        for (int e = 0; e < 3; e++) begin
          m = (e + 1) % 3;
          fresh[e] = 1'b1;
          rev[e] = 1'b0;
          slot[e] = 0;
          for (int k = 0; k < edge_count; k++) begin
            if (edge_from[k] == t.vid[e] && edge_to[k] == t.vid[m]) begin
              slot[e] = k; rev[e] = 1'b0; fresh[e] = 1'b0; break;
            end
            if (edge_from[k] == t.vid[m] && edge_to[k] == t.vid[e]) begin
              slot[e] = k; rev[e] = 1'b1; fresh[e] = 1'b0; break;
            end
          end
          if (fresh[e]) begin
            // new edge starts at the smaller point, equal points keep winding
            rev[e] = lies_after(t, e, m);
            s_from[e] = rev[e] ? t.vid[m] : t.vid[e];
            s_to[e]   = rev[e] ? t.vid[e] : t.vid[m];
            n_fresh++;
          end else begin
            n_reused++;
          end
        end
        if (edge_count + n_fresh > TABLE_DEPTH) begin
          r.table_full = 1'b1;
        end else begin
          for (int e = 0; e < 3; e++) begin
            if (fresh[e]) begin
              slot[e] = edge_count;
              edge_from[edge_count] = s_from[e];
              edge_to[edge_count] = s_to[e];
              edge_count++;
            end
            bump_count(slot[e], rev[e]);
            r.idx[2-e] = slot[e][OUT_IDX_W-1:0];
            r.rev[2-e] = rev[e];
          end
        end
      end
      r.mesh_closed = (open_edges == 0);
      r.edges_stored = edge_count[TOTAL_W-1:0];
      n_degen += r.degenerate;
      n_full += r.table_full;
      n_closed += r.mesh_closed;
      answers_q.insert(answers_q.size(), r);
    endfunction

    function void check_result(edge_result_t got);
      edge_result_t want;
      n_checked++;
      if (answers_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result transfer with no triangle waiting: %h", got);
        return;
      end
      want = answers_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch result %0d: idx ab/bc/ca exp %0d/%0d/%0d got %0d/%0d/%0d,",
                    " rev exp %b got %b, degen exp %b got %b, full exp %b got %b,",
                    " closed exp %b got %b, stored exp %0d got %0d"},
                   n_checked, want.idx[2], want.idx[1], want.idx[0],
                   got.idx[2], got.idx[1], got.idx[0], want.rev, got.rev,
                   want.degenerate, got.degenerate, want.table_full, got.table_full,
                   want.mesh_closed, got.mesh_closed, want.edges_stored,
                   got.edges_stored);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_vid [3];
  logic signed [31:0] in_pos [3][3];
  logic               out_valid;
  logic               out_ready = 1'b0;
  edge_result_t       got;
  bit                 idling_on = 1'b1;

  initial begin
    foreach (in_vid[i]) in_vid[i] = '0;
    foreach (in_pos[i, c]) in_pos[i][c] = '0;
  end

  mesh_edge_table_builder_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_vertex_a_index    (in_vid[0]),
    .in_vertex_b_index    (in_vid[1]),
    .in_vertex_c_index    (in_vid[2]),
    .in_vertex_a_x        (in_pos[0][0]),
    .in_vertex_a_y        (in_pos[0][1]),
    .in_vertex_a_z        (in_pos[0][2]),
    .in_vertex_b_x        (in_pos[1][0]),
    .in_vertex_b_y        (in_pos[1][1]),
    .in_vertex_b_z        (in_pos[1][2]),
    .in_vertex_c_x        (in_pos[2][0]),
    .in_vertex_c_y        (in_pos[2][1]),
    .in_vertex_c_z        (in_pos[2][2]),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_edge_ab_index    (got.idx[2]),
    .out_edge_ab_reversed (got.rev[2]),
    .out_edge_bc_index    (got.idx[1]),
    .out_edge_bc_reversed (got.rev[1]),
    .out_edge_ca_index    (got.idx[0]),
    .out_edge_ca_reversed (got.rev[0]),
    .out_degenerate       (got.degenerate),
    .out_table_full       (got.table_full),
    .out_mesh_closed      (got.mesh_closed),
    .out_edges_stored     (got.edges_stored)
  );

  edge_table_scoreboard sb = new();

  // --------------------------------------------------------------------------
  // monitor: transfers seen at the rising edge, input noted before result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    triangle_t seen;
    if (rst_n && in_valid && in_ready) begin
      seen.vid = in_vid;
      seen.pos = in_pos;
      sb.note_triangle(seen);
    end
    if (rst_n && out_valid && out_ready) sb.check_result(got);
  end

  // result side back-pressure, stalled about 22 percent of the time while idling is on
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= idling_on ? ($urandom_range(99) >= 22) : 1'b1;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  logic signed [31:0] pool_pos [64][3];

  // coordinates biased to the extremes and to ties
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0;
      3: return -32'sh1;
      4: return 32'sh1;
      default: return $urandom;
    endcase
  endfunction

  function automatic triangle_t make_tri(int a, int b, int c, bit own_pos);
    triangle_t t;
    t.vid[0] = a[15:0]; t.vid[1] = b[15:0]; t.vid[2] = c[15:0];
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        t.pos[i][k] = own_pos ? pool_pos[t.vid[i] % 64][k] : pick_coord();
    return t;
  endfunction

  // one triangle transfer, with a random hold-off before valid goes up
  task automatic send_triangle(triangle_t t);
    @(negedge clk);
    while (idling_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_vid <= t.vid;
    in_pos <= t.pos;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pos(int a, int b, int c,
                          logic signed [31:0] pa, logic signed [31:0] pb,
                          logic signed [31:0] pc);
    triangle_t t;
    t = make_tri(a, b, c, 1'b0);
    for (int k = 0; k < 3; k++) begin
      t.pos[0][k] = pa; t.pos[1][k] = pb; t.pos[2][k] = pc;
    end
    send_triangle(t);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int a, b, c;
    foreach (pool_pos[i, k]) pool_pos[i][k] = pick_coord();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: repeated indices in each position
    send_pos(5, 5, 6, 0, 0, 0);
    send_pos(5, 6, 6, 0, 0, 0);
    send_pos(6, 5, 6, 0, 0, 0);
    // extreme indices and coordinates, both orientations of new edges
    send_pos(0, 65535, 1, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_pos(65535, 0, 1, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_pos(0, 1, 65535, 32'sh8000_0000, 32'sh7fff_ffff, -1);
    // equal endpoints keep the triangle's direction
    send_pos(100, 101, 102, 7, 7, 7);
    send_pos(100, 102, 101, 7, 7, 7);
    // a closed tetrahedron
    send_pos(200, 201, 202, 1, 2, 3);
    send_pos(200, 203, 201, 1, 4, 2);
    send_pos(201, 203, 202, 2, 4, 3);
    send_pos(202, 203, 200, 3, 4, 1);
    // ties in x and y, decided by z
    begin
      triangle_t t;
      t = make_tri(300, 301, 302, 1'b0);
      for (int i = 0; i < 3; i++) begin
        t.pos[i][0] = 32'sh0001_0000; t.pos[i][1] = -32'sh5;
        t.pos[i][2] = (i == 1) ? 32'sh8000_0000 : 32'sh7fff_ffff - i;
      end
      send_triangle(t);
    end

    // saturation: this winding runs the ab and bc edges reversed and the ca edge forward, so the
    // counts reach both limits; then a new triangle and uses of its opposite winding
    for (int n = 0; n < 135; n++) send_pos(10, 11, 12, 3, 2, 1);
    send_pos(20, 21, 22, 1, 2, 3);
    for (int n = 0; n < 20; n++) send_pos(20, 22, 21, 1, 3, 2);

    // small vertex pool: some shared edges, some degenerate triangles
    for (int n = 0; n < 90; n++) begin
      a = $urandom_range(63);
      b = $urandom_range(63);
      c = $urandom_range(63);
      if ($urandom_range(9) != 0) begin
        while (b == a) b = $urandom_range(63);
        while (c == a || c == b) c = $urandom_range(63);
      end
      send_triangle(make_tri(a + 1000, b + 1000, c + 1000, $urandom_range(9) < 7));
    end

    // wide indices with no idling: fill the table past its end
    idling_on = 1'b0;
    for (int n = 0; n < 260; n++)
      send_triangle(make_tri($urandom, $urandom, $urandom, 1'b0));
    idling_on = 1'b1;
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(3) == 0)
        send_triangle(make_tri(1000 + $urandom_range(63), 1000 + $urandom_range(63),
                               1000 + $urandom_range(63), 1'b1));
      else
        send_triangle(make_tri($urandom, $urandom, $urandom, 1'b0));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.answers_q.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);

    $display("ran %0d results: %0d degenerate, %0d rejected as full, %0d closed,",
             sb.n_checked, sb.n_degen, sb.n_full, sb.n_closed);
    $display("  %0d edge lookups hit a stored edge, %0d edges stored at the end",
             sb.n_reused, sb.edge_count);
    if (sb.mismatches == 0 && sb.answers_q.size() == 0) begin
      $display("mesh_edge_table_builder_core_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.answers_q.size());
      $display("mesh_edge_table_builder_core_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("timeout");
    $display("mesh_edge_table_builder_core_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/metb_pkg.sv
rtl/core/metb_lane.sv
rtl/core/metb_merge.sv
rtl/core/mesh_edge_table_builder_core.sv
sim/mesh_edge_table_builder_core_tb.sv
